// ===== sv/vlpd_pkg.sv =====
// Shared types and constants for the varint length-prefixed deframer.
package vlpd_pkg;

    localparam int unsigned BYTE_W          = 8;
    localparam int unsigned VARINT_DATA_W   = 7;   // payload bits per varint byte
    localparam int unsigned VALUE_W         = 28;  // decoded varint / length width
    localparam int unsigned ROLE_W          = 3;
    localparam int unsigned ERR_W           = 2;
    localparam int unsigned PHASE_W         = 2;

    // Output tdata: payload_byte, header_value, payload_length, error_code
    localparam int unsigned M_FIELDS_W      = BYTE_W + 2 * VALUE_W + ERR_W;
    localparam int unsigned M_TDATA_W       = ((M_FIELDS_W + 7) / 8) * 8;
    localparam int unsigned M_PAD_W         = M_TDATA_W - M_FIELDS_W;

    // Byte roles
    localparam logic [ROLE_W-1:0] ROLE_LEN    = 3'd0;
    localparam logic [ROLE_W-1:0] ROLE_HDR    = 3'd1;
    localparam logic [ROLE_W-1:0] ROLE_DELIV  = 3'd2;
    localparam logic [ROLE_W-1:0] ROLE_DISC   = 3'd3;
    localparam logic [ROLE_W-1:0] ROLE_ERR    = 3'd4;

    // Sticky error codes
    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_LEN_LONG = 2'd1;
    localparam logic [ERR_W-1:0] ERR_HDR_LONG = 2'd2;
    localparam logic [ERR_W-1:0] ERR_OVERRUN  = 2'd3;

    // Parser phases
    localparam logic [PHASE_W-1:0] PH_LEN = 2'd0;
    localparam logic [PHASE_W-1:0] PH_HDR = 2'd1;
    localparam logic [PHASE_W-1:0] PH_PAY = 2'd2;
    localparam logic [PHASE_W-1:0] PH_ERR = 2'd3;

    typedef struct packed {
        logic [ROLE_W-1:0]  role;
        logic [BYTE_W-1:0]  payload_byte;
        logic [VALUE_W-1:0] header_value;
        logic [VALUE_W-1:0] payload_length;
        logic               frame_last;
        logic [ERR_W-1:0]   error_code;
    } t_result;

endpackage

// ===== sv/varint_length_prefixed_deframer.sv =====
// Top level of the varint length-prefixed deframer.
//
// Usage:
//   s_axis  : raw byte stream, one byte per transaction (tdata[7:0]).
//   m_axis  : one result transaction per input byte. tuser carries the
//             byte role (length, header, delivered, discarded, error);
//             tlast marks the final byte of a frame; tdata carries the
//             byte itself, decoded header, payload length and error code.
//   cfg     : one-bit write channel for suppress_delivery, always ready.
//             Write it only while no byte is in flight.
// Frame format: varint total length, varint header inside that length,
// then payload bytes up to the length. Zero-length frames are skipped.
// Throughput: one byte per cycle while m_axis_tready is high. The parser
// decodes combinationally between the input and result registers. An
// accepted byte waits in the input register and is shown on m_axis once
// it moves into the result register, when that register is free.
// Reset (i_rst_n low, synchronous) empties both registers, returns the
// parser to reading a length and clears suppress_delivery and any error.
// Errors (varint too long, header past frame end) are sticky: every later
// byte reports the error role until reset.
// When m_axis_tready is low the result holds and the input register keeps
// taking one more byte; after that s_axis_tready drops.
module varint_length_prefixed_deframer
    import vlpd_pkg::*;
#(
    parameter int unsigned VARINT_MAX_BYTES = 4
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [BYTE_W-1:0]    s_axis_tdata,   // [7:0] data_byte

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // [7:0] payload_byte, [35:8] header_value, [63:36] payload_length,
    // [65:64] error_code, rest zero
    output logic [M_TDATA_W-1:0] m_axis_tdata,
    output logic [ROLE_W-1:0]    m_axis_tuser,   // [2:0] role
    output logic                 m_axis_tlast,   // frame_last

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic                 i_cfg_data      // suppress_delivery
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    t_result           r_out;
    logic              r_suppress;

    logic              w_adv;    // result register free to load
    logic              w_step;   // input byte moves through the parser
    t_result           w_res;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;
    assign o_cfg_ready   = 1'b1;

    vlpd_core #(
        .VARINT_MAX_BYTES (VARINT_MAX_BYTES)
    ) u_core (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_byte     (r_in_byte),
        .i_suppress (r_suppress),
        .o_res      (w_res)
    );

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_suppress  <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                r_suppress <= i_cfg_data;
            end
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_step) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.role;
    assign m_axis_tlast  = r_out.frame_last;
    assign m_axis_tdata  = {M_PAD_W'(0), r_out.error_code, r_out.payload_length,
                            r_out.header_value, r_out.payload_byte};

endmodule

// ===== sv/vlpd_core.sv =====
// Frame parser state and per-byte decode logic.
module vlpd_core
    import vlpd_pkg::*;
#(
    parameter int unsigned VARINT_MAX_BYTES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  logic [BYTE_W-1:0] i_byte,
    input  logic              i_suppress,
    output t_result           o_res
);

    localparam int unsigned IDX_W   = (VARINT_MAX_BYTES > 1) ? $clog2(VARINT_MAX_BYTES) : 1;
    localparam int unsigned WIDE_W  = VALUE_W + VARINT_DATA_W * VARINT_MAX_BYTES;
    localparam int unsigned SHAMT_W = $clog2(WIDE_W);

    logic [PHASE_W-1:0] r_phase, n_phase;
    logic [VALUE_W-1:0] r_acc, n_acc;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [VALUE_W-1:0] r_remain, n_remain;
    logic [VALUE_W-1:0] r_hdr, n_hdr;
    logic [VALUE_W-1:0] r_plen, n_plen;
    logic [ERR_W-1:0]   r_err, n_err;

    logic               more;
    logic               idx_last;
    logic [SHAMT_W-1:0] shamt;
    logic [VALUE_W-1:0] bits_wide;
    logic [VALUE_W-1:0] acc_add;
    logic [VALUE_W-1:0] remain_dec;
    logic [VALUE_W-1:0] hdr_upd, plen_upd;
    logic [ROLE_W-1:0]  role;
    logic [BYTE_W-1:0]  pbyte;
    logic               last;

    assign more       = i_byte[BYTE_W-1];
    assign idx_last   = (r_idx == IDX_W'(VARINT_MAX_BYTES - 1));
    assign shamt      = SHAMT_W'(r_idx) * SHAMT_W'(VARINT_DATA_W);
    // bits beyond the 28-bit value fall off the top
    assign bits_wide  = VALUE_W'(i_byte[VARINT_DATA_W-1:0]) << shamt;
    assign acc_add    = r_acc | bits_wide;
    assign remain_dec = r_remain - VALUE_W'(1);

    always_comb begin
        n_phase  = r_phase;
        n_acc    = r_acc;
        n_idx    = r_idx;
        n_remain = r_remain;
        hdr_upd  = r_hdr;
        plen_upd = r_plen;
        n_err    = r_err;
        role     = ROLE_ERR;
        pbyte    = '0;
        last     = 1'b0;

        if (i_step) begin
            unique case (r_phase)
                PH_LEN: begin
                    role = ROLE_LEN;
                    if (more) begin
                        if (idx_last) begin
                            n_phase = PH_ERR;
                            n_err   = ERR_LEN_LONG;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                            n_acc = acc_add;
                        end
                    end else begin
                        n_remain = acc_add;
                        n_acc    = '0;
                        n_idx    = '0;
                        hdr_upd  = '0;
                        plen_upd = '0;
                        // zero length: stay and read the next length
                        if (acc_add != '0) begin
                            n_phase = PH_HDR;
                        end
                    end
                end
                PH_HDR: begin
                    role     = ROLE_HDR;
                    n_remain = remain_dec;
                    if (more) begin
                        if (idx_last) begin
                            n_phase = PH_ERR;
                            n_err   = ERR_HDR_LONG;
                        end else if (remain_dec == '0) begin
                            n_phase = PH_ERR;
                            n_err   = ERR_OVERRUN;
                        end else begin
                            n_idx = r_idx + IDX_W'(1);
                            n_acc = acc_add;
                        end
                    end else begin
                        hdr_upd  = acc_add;
                        plen_upd = remain_dec;
                        n_acc    = '0;
                        n_idx    = '0;
                        if (remain_dec == '0) begin
                            last    = 1'b1;
                            n_phase = PH_LEN;
                        end else begin
                            n_phase = PH_PAY;
                        end
                    end
                end
                PH_PAY: begin
                    role     = i_suppress ? ROLE_DISC : ROLE_DELIV;
                    pbyte    = i_byte;
                    n_remain = remain_dec;
                    if (remain_dec == '0) begin
                        last    = 1'b1;
                        n_phase = PH_LEN;
                        n_acc   = '0;
                        n_idx   = '0;
                    end
                end
                PH_ERR: begin
                    role = ROLE_ERR;
                end
                default: begin
                    role = ROLE_ERR;
                end
            endcase
        end

        // frame info is cleared once the last byte has reported it
        n_hdr  = last ? '0 : hdr_upd;
        n_plen = last ? '0 : plen_upd;

        if (n_phase == PH_ERR) begin
            o_res.role           = ROLE_ERR;
            o_res.payload_byte   = '0;
            o_res.header_value   = '0;
            o_res.payload_length = '0;
            o_res.frame_last     = 1'b0;
            o_res.error_code     = n_err;
        end else begin
            o_res.role           = role;
            o_res.payload_byte   = pbyte;
            o_res.header_value   = hdr_upd;
            o_res.payload_length = plen_upd;
            o_res.frame_last     = last;
            o_res.error_code     = ERR_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_LEN;
            r_acc    <= '0;
            r_idx    <= '0;
            r_remain <= '0;
            r_hdr    <= '0;
            r_plen   <= '0;
            r_err    <= ERR_NONE;
        end else begin
            r_phase  <= n_phase;
            r_acc    <= n_acc;
            r_idx    <= n_idx;
            r_remain <= n_remain;
            r_hdr    <= n_hdr;
            r_plen   <= n_plen;
            r_err    <= n_err;
        end
    end

endmodule

// ===== sv/vlpd_checker.sv =====
// Port-level checks for the deframer, bound to the top level.
module vlpd_checker
    import vlpd_pkg::*;
(
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [M_TDATA_W-1:0] m_axis_tdata,
    input logic [ROLE_W-1:0]    m_axis_tuser,
    input logic                 m_axis_tlast
);

    localparam int unsigned ERR_LO  = BYTE_W + 2 * VALUE_W;
    localparam int unsigned PLEN_LO = BYTE_W + VALUE_W;

    // error results carry only the code
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == ROLE_ERR |->
            m_axis_tdata[ERR_LO-1:0] == '0 && !m_axis_tlast &&
            m_axis_tdata[ERR_LO +: ERR_W] != ERR_NONE)
        else $error("error result not clean");

    // no error code outside the error role
    a_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ROLE_ERR |->
            m_axis_tdata[ERR_LO +: ERR_W] == ERR_NONE)
        else $error("error code on a normal result");

    // a header byte ends a frame only when the payload is empty
    a_hdr_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tlast && m_axis_tuser == ROLE_HDR |->
            m_axis_tdata[PLEN_LO +: VALUE_W] == '0)
        else $error("frame ends on header with payload pending");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
            $stable(m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind varint_length_prefixed_deframer vlpd_checker u_vlpd_checker (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the varint length-prefixed deframer.
module tb
    import vlpd_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned VARINT_MAX = 4;  // must match the DUT parameter
    localparam int unsigned MAX_REPORTS = 10;

    // ------------------------------------------------------------------
    // Clock, reset and DUT signals. Every input starts at a known value.
    // ------------------------------------------------------------------
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;

    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata = '0;      // [7:0] data_byte

    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // [7:0] payload_byte, [35:8] header_value, [63:36] payload_length,
    // [65:64] error_code, rest zero
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic [ROLE_W-1:0]    m_axis_tuser;           // [2:0] role
    logic                 m_axis_tlast;           // frame_last

    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic                 i_cfg_data = 1'b0;      // suppress_delivery

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    varint_length_prefixed_deframer #(
        .VARINT_MAX_BYTES (VARINT_MAX)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data)
    );

    // ------------------------------------------------------------------
    // Deframer predictor state: a private copy of the parser registers
    // and the suppress_delivery setting.
    // ------------------------------------------------------------------
    logic [PHASE_W-1:0] st_phase;
    logic [VALUE_W-1:0] st_acc;         // varint being assembled
    int unsigned        st_index;       // bytes of the varint seen so far
    logic [VALUE_W-1:0] st_remaining;   // bytes left in the frame
    logic [VALUE_W-1:0] st_header;
    logic [VALUE_W-1:0] st_plen;
    logic [ERR_W-1:0]   st_err;
    logic               st_suppress;

    t_result     expected_results[$];   // one per accepted byte, oldest first
    logic [7:0]  tx_bytes[$];           // byte stream waiting to be sent

    int unsigned n_sent = 0;
    int unsigned n_checked = 0;
    int unsigned n_frames = 0;
    int unsigned n_mismatch = 0;
    int unsigned n_cfg_writes = 0;
    int unsigned err_kind = 0;

    // Handshake pacing knobs, owned by the test sequence.
    bit          tx_gaps_on = 1'b1;
    bit          rx_stalls_on = 1'b1;
    int unsigned tx_burst_left = 0;
    int unsigned hold_cycles = 0;       // forced receiver hold-off
    int unsigned rx_run = 0;
    bit          rx_ready_state = 1'b1;

    function automatic void reset_deframer_model();
        st_phase     = PH_LEN;
        st_acc       = '0;
        st_index     = 0;
        st_remaining = '0;
        st_header    = '0;
        st_plen      = '0;
        st_err       = ERR_NONE;
        st_suppress  = 1'b0;
    endfunction

    // Fold 7 data bits into the varint; bits past 28 are dropped.
    function automatic void fold_varint_bits(input logic [7:0] b);
        if (st_index * 7 < VALUE_W)
            st_acc = st_acc | (VALUE_W'(b[6:0]) << (st_index * 7));
    endfunction

    // Advance the predictor by one stream byte and return its result.
    function automatic t_result deframe(input logic [7:0] b);
        t_result r;
        logic    last;
        r    = '0;
        last = 1'b0;
        r.role = ROLE_ERR;
        case (st_phase)
            PH_LEN: begin
                r.role = ROLE_LEN;
                fold_varint_bits(b);
                if (b[7]) begin
                    st_index++;
                    if (st_index >= VARINT_MAX) begin
                        st_phase = PH_ERR;
                        st_err   = ERR_LEN_LONG;
                    end
                end else begin
                    st_remaining = st_acc;
                    st_acc       = '0;
                    st_index     = 0;
                    st_header    = '0;
                    st_plen      = '0;
                    // zero length: stay here, next byte starts a new length
                    if (st_remaining != '0)
                        st_phase = PH_HDR;
                end
            end
            PH_HDR: begin
                r.role = ROLE_HDR;
                fold_varint_bits(b);
                st_remaining = st_remaining - 1'b1;
                if (b[7]) begin
                    st_index++;
                    // too-long takes priority over running off the frame
                    if (st_index >= VARINT_MAX) begin
                        st_phase = PH_ERR;
                        st_err   = ERR_HDR_LONG;
                    end else if (st_remaining == '0) begin
                        st_phase = PH_ERR;
                        st_err   = ERR_OVERRUN;
                    end
                end else begin
                    st_header = st_acc;
                    st_plen   = st_remaining;
                    st_acc    = '0;
                    st_index  = 0;
                    if (st_remaining == '0) begin
                        last     = 1'b1;
                        st_phase = PH_LEN;
                    end else begin
                        st_phase = PH_PAY;
                    end
                end
            end
            PH_PAY: begin
                r.role         = st_suppress ? ROLE_DISC : ROLE_DELIV;
                r.payload_byte = b;
                st_remaining   = st_remaining - 1'b1;
                if (st_remaining == '0) begin
                    last     = 1'b1;
                    st_phase = PH_LEN;
                    st_acc   = '0;
                    st_index = 0;
                end
            end
            default: ;
        endcase

        if (st_phase == PH_ERR) begin
            r            = '0;
            r.role       = ROLE_ERR;
            r.error_code = st_err;
        end else begin
            r.header_value   = st_header;
            r.payload_length = st_plen;
            r.frame_last     = last;
            if (last) begin
                st_header = '0;
                st_plen   = '0;
                n_frames++;
            end
        end
        return r;
    endfunction

    function automatic string fmt_result(input t_result r);
        return $sformatf("role=%0d byte=%02h hdr=%07h plen=%07h last=%0d err=%0d",
                         r.role, r.payload_byte, r.header_value, r.payload_length,
                         r.frame_last, r.error_code);
    endfunction

    // ------------------------------------------------------------------
    // Stream builders
    // ------------------------------------------------------------------
    function automatic int unsigned varint_size(input logic [VALUE_W-1:0] v);
        int unsigned n;
        n = 1;
        while (n < VARINT_MAX && (v >> (7 * n)) != '0)
            n++;
        return n;
    endfunction

    // Encode v, padded with non-minimal continuation bytes to min_bytes.
    function automatic void put_varint(input logic [VALUE_W-1:0] v,
                                       input int unsigned min_bytes);
        int unsigned n;
        logic [7:0]  b;
        n = varint_size(v);
        if (min_bytes > n)
            n = min_bytes;
        for (int unsigned i = 0; i < n; i++) begin
            b      = 8'(v >> (7 * i)) & 8'h7f;
            b[7]   = (i != n - 1);
            tx_bytes.push_back(b);
        end
    endfunction

    function automatic void add_frame(input logic [VALUE_W-1:0] hdr,
                                      input int unsigned plen,
                                      input int unsigned len_pad,
                                      input int unsigned hdr_pad);
        int unsigned hn;
        hn = varint_size(hdr);
        if (hdr_pad > hn)
            hn = hdr_pad;
        put_varint(VALUE_W'(hn + plen), len_pad);
        put_varint(hdr, hn);
        repeat (plen)
            tx_bytes.push_back(8'($urandom()));
    endfunction

    function automatic void add_random_frame();
        logic [VALUE_W-1:0] hdr;
        int unsigned        plen;
        int unsigned        pick;
        case ($urandom_range(0, 3))
            0:       hdr = VALUE_W'($urandom_range(0, 127));
            1:       hdr = VALUE_W'($urandom_range(0, 16383));
            2:       hdr = VALUE_W'($urandom_range(0, 2097151));
            default: hdr = VALUE_W'($urandom());
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            // zero-length frame, sometimes encoded non-minimally
            put_varint('0, $urandom_range(1, VARINT_MAX));
            return;
        end
        if (pick < 20)
            plen = 0;                           // header fills the frame
        else if (pick < 95)
            plen = $urandom_range(1, 24);
        else
            plen = $urandom_range(100, 300);
        add_frame(hdr, plen,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, VARINT_MAX) : 1,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(1, VARINT_MAX) : 1);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one byte per call, bursts with random gaps between them.
    // tvalid stays high between back-to-back bytes.
    // ------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        if (tx_gaps_on && tx_burst_left == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            tx_burst_left = $urandom_range(1, 16);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        do @(posedge i_clk); while (!s_axis_tready);
        if (tx_burst_left > 0)
            tx_burst_left--;
        expected_results.push_back(deframe(b));
        n_sent++;
    endtask

    task automatic send_stream();
        while (tx_bytes.size() != 0)
            send_byte(tx_bytes.pop_front());
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Every byte yields a result, so an empty queue means the pipe is empty.
    task automatic wait_drained();
        while (expected_results.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_suppress(input logic v);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        st_suppress = v;
        n_cfg_writes++;
    endtask

    // ------------------------------------------------------------------
    // Receiver: alternating ready/stall runs of random length, a no-stall
    // mode, and a counted hold-off used to back the pipe up.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles--;
            m_axis_tready <= 1'b0;
        end else if (!rx_stalls_on) begin
            m_axis_tready <= 1'b1;
        end else begin
            if (rx_run == 0) begin
                rx_ready_state = !rx_ready_state;
                rx_run = rx_ready_state ? $urandom_range(1, 12) : $urandom_range(1, 5);
            end else begin
                rx_run--;
            end
            m_axis_tready <= rx_ready_state;
        end
    end

    // ------------------------------------------------------------------
    // Result checker: every output transaction against the oldest
    // expectation.
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : result_check
        t_result seen;
        t_result want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            seen.role           = m_axis_tuser;
            seen.payload_byte   = m_axis_tdata[7:0];
            seen.header_value   = m_axis_tdata[35:8];
            seen.payload_length = m_axis_tdata[63:36];
            seen.frame_last     = m_axis_tlast;
            seen.error_code     = m_axis_tdata[65:64];
            if (expected_results.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_REPORTS)
                    $display("%0t: unexpected result role=%0d byte=%02h", $realtime,
                             seen.role, seen.payload_byte);
            end else begin
                want = expected_results.pop_front();
                n_checked++;
                if (seen !== want) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_REPORTS)
                        $display("%0t: result %0d exp %s / got %s", $realtime,
                                 n_checked, fmt_result(want), fmt_result(seen));
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes and the well-formed corner cases, delivery on.
    task automatic test_directed_frames();
        put_varint('0, 1);                     // zero length, minimal
        put_varint('0, VARINT_MAX);            // zero length, padded
        add_frame('0, 0, 1, 1);                // one-byte frame: header fills it
        add_frame(28'hFFF_FFFF, 0, 1, 1);      // widest header, fills the frame
        // 4-byte length (7), 2-byte header (128), payload with bit extremes
        put_varint(VALUE_W'(7), VARINT_MAX);
        put_varint(VALUE_W'(128), 1);
        tx_bytes.push_back(8'h00);
        tx_bytes.push_back(8'hff);
        tx_bytes.push_back(8'h55);
        tx_bytes.push_back(8'haa);
        tx_bytes.push_back(8'h80);
        send_stream();
    endtask

    // Payload marked discarded while suppressed, delivered again after.
    task automatic test_suppress_delivery();
        write_suppress(1'b1);
        add_frame(VALUE_W'(5), 3, 1, 1);
        add_frame('0, 0, 1, 1);
        send_stream();
        write_suppress(1'b0);
        add_frame(VALUE_W'(9), 2, 1, 2);
        send_stream();
    endtask

    // Bulk random well-formed frames; the setting flips between phases
    // and one phase runs with no idling on either side.
    task automatic test_random_frames();
        for (int unsigned ph = 0; ph < 6; ph++) begin
            tx_gaps_on   = (ph != 2);
            rx_stalls_on = (ph != 2);
            while (tx_bytes.size() < 250)
                add_random_frame();
            send_stream();
            write_suppress((ph % 2) == 0);
        end
        tx_gaps_on   = 1'b1;
        rx_stalls_on = 1'b1;
    endtask

    // Long receiver hold-off while the sender keeps offering bytes.
    task automatic test_backpressure();
        tx_gaps_on  = 1'b0;
        hold_cycles = 300;
        add_frame(VALUE_W'($urandom()), 80, 1, 1);
        send_stream();
        tx_gaps_on = 1'b1;
    endtask

    // Errors are sticky until reset, so only one fault kind per run;
    // the seed picks it. Trailing noise must all report the error.
    task automatic test_sticky_error();
        err_kind = $urandom_range(0, 3);
        case (err_kind)
            0: repeat (VARINT_MAX) tx_bytes.push_back(8'h80 | 8'($urandom_range(0, 127)));
            1: begin                           // header varint too long
                put_varint(VALUE_W'(VARINT_MAX + 2), 1);
                repeat (VARINT_MAX) tx_bytes.push_back(8'hff);
            end
            2: begin                           // header runs off the frame
                put_varint(VALUE_W'(2), 1);
                tx_bytes.push_back(8'h80);
                tx_bytes.push_back(8'h81);
            end
            default: begin                     // both on one byte: too-long wins
                put_varint(VALUE_W'(VARINT_MAX), 1);
                repeat (VARINT_MAX) tx_bytes.push_back(8'h80);
            end
        endcase
        repeat (40)
            tx_bytes.push_back(8'($urandom()));
        send_stream();
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        reset_deframer_model();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_frames();
        test_suppress_delivery();
        test_random_frames();
        test_backpressure();
        test_sticky_error();

        wait_drained();
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes, checked %0d results, %0d complete frames.",
                 n_sent, n_checked, n_frames);
        $display("%0d config writes, closing fault kind %0d, %0d mismatches.",
                 n_cfg_writes, err_kind, n_mismatch);
        if (n_mismatch == 0 && expected_results.size() == 0) begin
            $display("varint_length_prefixed_deframer: match");
        end else begin
            $display("varint_length_prefixed_deframer: mismatch");
        end
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial begin
        #5ms;
        $display("varint_length_prefixed_deframer: mismatch");
        $finish;
    end

endmodule

// ===== sim.f =====
sv/vlpd_pkg.sv
sv/vlpd_core.sv
sv/varint_length_prefixed_deframer.sv
sv/vlpd_checker.sv
tb/tb.sv
